// ===== src/wpr_pkg.sv =====
// Package for the widest-path router: widths, opcodes and constants.
// Used by every module of the block; depends on nothing.
package wpr_pkg;
	localparam int NodesDefault = 16;
	localparam int VertW = 4;
	localparam int LinkW = 16;
	localparam int BwW = 17;
	localparam logic [BwW-1:0] Unbounded = 17'h10000;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_CLEAR = 2'd1,
		OP_QUERY = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0] op;
		logic [VertW-1:0] vert_a;
		logic [VertW-1:0] vert_b;
		logic [LinkW-1:0] link_width;
	} in_word_t;

	typedef struct packed {
		logic [VertW-1:0] path_node;
		logic [BwW-1:0] bottleneck;
		logic found;
		logic last;
	} out_word_t;
endpackage

// ===== src/wpr_in_if.sv =====
// Valid/ready channel carrying one input word of the router.
// Depends on wpr_pkg.
interface wpr_in_if import wpr_pkg::*; ();
	logic valid;
	logic ready;
	logic [1:0] op;
	logic [VertW-1:0] vert_a;
	logic [VertW-1:0] vert_b;
	logic [LinkW-1:0] link_width;
	modport source(output valid, op, vert_a, vert_b, link_width, input ready);
	modport sink(input valid, op, vert_a, vert_b, link_width, output ready);
endinterface

// ===== src/wpr_out_if.sv =====
// Valid/ready channel carrying one result word of the router.
// Depends on wpr_pkg.
interface wpr_out_if import wpr_pkg::*; ();
	logic valid;
	logic ready;
	logic [VertW-1:0] path_node;
	logic [BwW-1:0] bottleneck;
	logic found;
	logic last;
	modport source(output valid, path_node, bottleneck, found, last, input ready);
	modport sink(input valid, path_node, bottleneck, found, last, output ready);
endinterface

// ===== src/widest_path_router.sv =====
// Widest-path router: a graph of up to Nodes vertices held in a link memory.
// An add-edge word reads both directions of the link and writes each one that
// is absent or narrower; a clear word empties the memory as it is taken. A
// query scans all vertices and reads one neighbor link per cycle for every
// finished vertex, in at most Nodes rounds, then walks the path back and sends
// one result word per path vertex; the single read port of the link memory sets the scan's pace.
module widest_path_router import wpr_pkg::*; #(
	parameter int Nodes = NodesDefault
) (
	input logic clk,
	input logic arst_n,
	wpr_in_if.sink in_ch,
	wpr_out_if.source out_ch
);
	wpr_engine #(.Nodes(Nodes)) u_engine (
		.clk, .arst_n, .in_ch, .out_ch
	);
endmodule

// ===== src/wpr_link_mem.sv =====
// Adjacency memory of the router: link widths in a synchronous RAM with
// registered read data and per-entry valid bits in flip-flops.
// Depends on wpr_pkg.
module wpr_link_mem import wpr_pkg::*; #(
	parameter int Nodes = NodesDefault,
	localparam int IdxW = 2 * $clog2(Nodes)
) (
	input logic clk,
	input logic arst_n,
	input logic clear,
	input logic we,
	input logic [IdxW-1:0] waddr,
	input logic [LinkW-1:0] wdata,
	input logic [IdxW-1:0] raddr,
	output logic [LinkW-1:0] rdata,
	output logic rvalid
);
	logic [LinkW-1:0] mem [1 << IdxW];
	logic [(1 << IdxW)-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rvalid <= 1'b0;
		end else begin
			rvalid <= vld_q[raddr] && !(clear);
			if (clear) begin
				vld_q <= '0;
			end else if (we) begin
				vld_q[waddr] <= 1'b1;
			end
		end
	end
endmodule

// ===== src/wpr_engine.sv =====
// Sequencer of the router: edge updates by read-modify-write of the link
// memory and the widest-path search with path output. Depends on wpr_pkg
// and wpr_link_mem.
module wpr_engine import wpr_pkg::*; #(
	parameter int Nodes = NodesDefault,
	localparam int NW = $clog2(Nodes),
	localparam int IdxW = 2 * NW
) (
	input logic clk,
	input logic arst_n,
	wpr_in_if.sink in_ch,
	wpr_out_if.source out_ch
);
	typedef enum logic [3:0] {
		S_IDLE, S_ADD_RD, S_ADD_WR, S_SCAN, S_PICK, S_RELAX, S_RELAX_LAST,
		S_WALK, S_EMIT, S_NF
	} state_t;

	state_t state_q;
	logic [NW-1:0] src_q, dst_q, sel_q, v_q, cur_q;
	logic [LinkW-1:0] w_q;
	logic pass_q;
	logic [BwW-1:0] bw_q [Nodes];
	logic [NW-1:0] pred_q [Nodes];
	logic [Nodes-1:0] reach_q, fin_q;
	logic [NW-1:0] chain_q [Nodes];
	logic [NW:0] len_q;
	logic any_q;
	logic [BwW-1:0] bestw_q;
	logic [NW-1:0] rd_v_s1;
	logic out_valid_q;
	out_word_t out_q;

	logic clear, we;
	logic [IdxW-1:0] waddr, raddr;
	logic [LinkW-1:0] wdata, rdata;
	logic rvalid;
	logic [BwW-1:0] cand;

	wpr_link_mem #(.Nodes(Nodes)) u_mem (
		.clk, .arst_n, .clear, .we, .waddr, .wdata, .raddr, .rdata, .rvalid
	);

	assign in_ch.ready = (state_q == S_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.path_node = out_q.path_node;
	assign out_ch.bottleneck = out_q.bottleneck;
	assign out_ch.found = out_q.found;
	assign out_ch.last = out_q.last;

	logic in_fire, out_free, emit_go;
	logic a_ok, b_ok;
	assign in_fire = in_ch.valid && in_ch.ready;
	assign out_free = !out_valid_q || out_ch.ready;
	assign emit_go = ((state_q == S_EMIT) || (state_q == S_NF)) && out_free;
	assign a_ok = (32'(in_ch.vert_a) < 32'(Nodes));
	assign b_ok = (32'(in_ch.vert_b) < 32'(Nodes));

	assign clear = in_fire && (in_ch.op == OP_CLEAR);
	assign we = (state_q == S_ADD_WR) && (!rvalid || rdata < w_q);
	assign wdata = w_q;
	assign waddr = pass_q ? IdxW'({v_q, sel_q}) : IdxW'({sel_q, v_q});
	assign cand = ({1'b0, rdata} < bw_q[sel_q]) ? {1'b0, rdata} : bw_q[sel_q];

	always_comb begin
		unique case (state_q)
			S_ADD_RD, S_ADD_WR: raddr = waddr;
			default: raddr = IdxW'({sel_q, v_q});
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			reach_q <= '0;
			fin_q <= '0;
			pass_q <= 1'b0;
			any_q <= 1'b0;
			len_q <= '0;
		end else begin
			out_valid_q <= emit_go || (out_valid_q && !out_ch.ready);
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						sel_q <= NW'(in_ch.vert_a);
						src_q <= NW'(in_ch.vert_a);
						dst_q <= NW'(in_ch.vert_b);
						w_q <= in_ch.link_width;
						pass_q <= 1'b0;
						if (in_ch.op == OP_QUERY) begin
							v_q <= '0;
						end else begin
							v_q <= NW'(in_ch.vert_b);
						end
						if (in_ch.op == OP_ADD && a_ok && b_ok) begin
							state_q <= S_ADD_RD;
						end else if (in_ch.op == OP_QUERY) begin
							if (!(a_ok && b_ok)) begin
								state_q <= S_NF;
							end else begin
								fin_q <= '0;
								reach_q <= Nodes'(1) << NW'(in_ch.vert_a);
								bw_q[NW'(in_ch.vert_a)] <= Unbounded;
								any_q <= 1'b0;
								state_q <= S_SCAN;
							end
						end
					end
				end
				S_ADD_RD: state_q <= S_ADD_WR;
				S_ADD_WR: begin
					if (!pass_q) begin
						pass_q <= 1'b1;
						state_q <= S_ADD_RD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (reach_q[v_q] && !fin_q[v_q] && (!any_q || bw_q[v_q] >= bestw_q)) begin
						any_q <= 1'b1;
						bestw_q <= bw_q[v_q];
						sel_q <= v_q;
					end
					if (v_q == NW'(Nodes - 1)) begin
						state_q <= S_PICK;
					end else begin
						v_q <= v_q + 1'b1;
					end
				end
				S_PICK: begin
					v_q <= '0;
					if (!any_q) begin
						state_q <= S_NF;
					end else if (sel_q == dst_q) begin
						cur_q <= dst_q;
						len_q <= '0;
						state_q <= S_WALK;
					end else begin
						fin_q[sel_q] <= 1'b1;
						state_q <= S_RELAX;
					end
				end
				S_RELAX, S_RELAX_LAST: begin
					rd_v_s1 <= v_q;
					if (state_q == S_RELAX) begin
						if (v_q == NW'(Nodes - 1)) begin
							state_q <= S_RELAX_LAST;
						end else begin
							v_q <= v_q + 1'b1;
						end
					end
					if (v_q != '0 || state_q == S_RELAX_LAST) begin
						if (rvalid && (!reach_q[rd_v_s1] || bw_q[rd_v_s1] < cand)) begin
							reach_q[rd_v_s1] <= 1'b1;
							bw_q[rd_v_s1] <= cand;
							pred_q[rd_v_s1] <= sel_q;
						end
					end
					if (state_q == S_RELAX_LAST) begin
						v_q <= '0;
						any_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_WALK: begin
					chain_q[len_q[NW-1:0]] <= cur_q;
					len_q <= len_q + 1'b1;
					cur_q <= pred_q[cur_q];
					if (cur_q == src_q || len_q == (NW+1)'(Nodes - 1)) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_q.path_node <= VertW'(chain_q[NW'(len_q - 1'b1)]);
						out_q.bottleneck <= bw_q[dst_q];
						out_q.found <= 1'b1;
						out_q.last <= (len_q == (NW+1)'(1));
						len_q <= len_q - 1'b1;
						if (len_q == (NW+1)'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_NF: begin
					if (out_free) begin
						out_q <= '{path_node: '0, bottleneck: '0, found: 1'b0, last: 1'b1};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== src/wpr_checker.sv =====
// Port-level checker for the widest-path router, bound to the top level.
// Depends on wpr_pkg and the channel interfaces.
module wpr_checker import wpr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic found,
	input logic last,
	input logic [BwW-1:0] bottleneck
);
	a_nf_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> last && bottleneck == '0)
		else $error("not-found word must be last with zero width");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("input taken while a path is still being sent");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bottleneck))
		else $error("stalled result word changed");
	a_bw_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> bottleneck <= Unbounded)
		else $error("bottleneck out of range");
endmodule

bind widest_path_router wpr_checker u_wpr_checker (
	.clk(clk), .arst_n(arst_n),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.found(out_ch.found), .last(out_ch.last), .bottleneck(out_ch.bottleneck)
);
